// ----- src/wpc_pkg.sv -----
// Shared types, constants and a helper function for the waveform plot pixel compositor.
`default_nettype none
package wpc_pkg;

    // Sample store data width (signed screen row of the trace)
    localparam int SAMPLE_W = 16;

    // Grid pitch
    localparam int MINOR_DX = 10;
    localparam int MINOR_DY = 8;
    localparam int MAJOR_DX = 50;
    localparam int MAJOR_DY = 40;

    // Enough multiples of the finest pitch to cover an 8-bit coordinate
    localparam int MULT_SPAN = 255 / MINOR_DY + 1;

    // Item action codes
    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    // Colour classes
    typedef logic [2:0] colour_t;
    localparam colour_t CLS_BACKGROUND = 3'd0;
    localparam colour_t CLS_GRID       = 3'd1;
    localparam colour_t CLS_CENTRE     = 3'd2;
    localparam colour_t CLS_TRACE      = 3'd3;
    localparam colour_t CLS_MARKER     = 3'd4;

    // Register indexes (byte address = 4 * index)
    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_LEFT_COLUMN   = 3'd0;
    localparam reg_index_t REG_RIGHT_COLUMN  = 3'd1;
    localparam reg_index_t REG_TOP_ROW       = 3'd2;
    localparam reg_index_t REG_BOTTOM_ROW    = 3'd3;
    localparam reg_index_t REG_CENTRE_ROW    = 3'd4;
    localparam reg_index_t REG_POINTS_IN_USE = 3'd5;
    localparam reg_index_t REG_MARKER_ENABLE = 3'd6;
    localparam reg_index_t REG_MARKER_COLUMN = 3'd7;

    // Register reset values
    localparam logic [7:0] RST_LEFT_COLUMN   = 8'd0;
    localparam logic [7:0] RST_RIGHT_COLUMN  = 8'd159;
    localparam logic [7:0] RST_TOP_ROW       = 8'd0;
    localparam logic [7:0] RST_BOTTOM_ROW    = 8'd127;
    localparam logic [7:0] RST_CENTRE_ROW    = 8'd64;
    localparam logic [8:0] RST_POINTS_IN_USE = 9'd2;
    localparam logic       RST_MARKER_ENABLE = 1'b0;
    localparam logic [7:0] RST_MARKER_COLUMN = 8'd0;

    // Per-pixel info carried from the accept stage to the class stage
    typedef struct packed {
        logic [7:0] row;
        logic [7:0] screen_col;
        logic       col_zero;
        colour_t    base_class;
        logic       marker_hit;
    } pix_info_t;

    // True when v is a multiple of step (step >= MINOR_DY); parallel compares
    function automatic logic is_multiple(input logic [7:0] v, input logic [7:0] step);
        logic [15:0] prod;
        logic        hit;
        hit = 1'b0;
        for (int k = 0; k < MULT_SPAN; k++) begin
            prod = 16'(k) * {8'd0, step};
            if (prod[15:8] == 8'd0 && prod[7:0] == v) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ----- src/wpc_sample_ram.sv -----
// Trace sample memory: one write port, two registered read ports.
`default_nettype none
module wpc_sample_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [wpc_pkg::SAMPLE_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr_a,
    input  wire logic [AW-1:0]                 rd_addr_b,
    output logic      [wpc_pkg::SAMPLE_W-1:0]  rd_data_a,
    output logic      [wpc_pkg::SAMPLE_W-1:0]  rd_data_b
);
    import wpc_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ----- src/waveform_plot_pixel_compositor_unit.sv -----
// Top level of the waveform plot pixel compositor: config port, accept stage, class stage.
`default_nettype none
// Waveform plot pixel compositor. Holds one signed trace sample per plot column
// in a dual-read sample memory and answers pixel requests with a colour class
// (background, grid/border, centre line, trace, marker). A store item
// (s_action = 0) writes s_sample_row at s_column_index; a request item
// (s_action = 1) names a column offset and a screen row and yields one result
// item carrying the class and the screen column, or nothing when the pixel lies
// outside the window or past the columns in use. Rate: one item per clock while
// s_ready is high, stores and requests freely mixed. A result is presented on
// m_valid from the output register: the accepting edge registers the current and
// previous column samples, then the class stage clamps them and loads the class
// into the output register once that register is free. While the output is
// stalled one more request can wait in the read stage; after that s_ready drops.
// A store is visible to a request accepted in the very next cycle. The sample
// memory has no reset and no clearing pass; a request must only touch a column,
// and the column before it, that were stored. Configuration (APB, pready tied
// high, register i at byte 4*i) may only be written while no item is in flight.
module waveform_plot_pixel_compositor_unit #(
    parameter int SAMPLE_DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [4:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // input item channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [7:0]                    s_column_index,
    input  wire logic signed [15:0]            s_sample_row,
    input  wire logic [7:0]                    s_pixel_row,
    // result item channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output wpc_pkg::colour_t                   m_colour_class,
    output logic      [7:0]                    m_screen_column
);
    import wpc_pkg::*;

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    // wide enough for min(points, window width, depth) and for the depth itself
    localparam int USE_W = ($clog2(SAMPLE_DEPTH + 1) > 9) ? $clog2(SAMPLE_DEPTH + 1) : 9;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] left_column_reg,   left_column_next;
    logic [7:0] right_column_reg,  right_column_next;
    logic [7:0] top_row_reg,       top_row_next;
    logic [7:0] bottom_row_reg,    bottom_row_next;
    logic [7:0] centre_row_reg,    centre_row_next;
    logic [8:0] points_in_use_reg, points_in_use_next;
    logic       marker_enable_reg, marker_enable_next;
    logic [7:0] marker_column_reg, marker_column_next;

    reg_index_t cfg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        left_column_next   = left_column_reg;
        right_column_next  = right_column_reg;
        top_row_next       = top_row_reg;
        bottom_row_next    = bottom_row_reg;
        centre_row_next    = centre_row_reg;
        points_in_use_next = points_in_use_reg;
        marker_enable_next = marker_enable_reg;
        marker_column_next = marker_column_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_LEFT_COLUMN:   left_column_next   = pwdata[7:0];
                REG_RIGHT_COLUMN:  right_column_next  = pwdata[7:0];
                REG_TOP_ROW:       top_row_next       = pwdata[7:0];
                REG_BOTTOM_ROW:    bottom_row_next    = pwdata[7:0];
                REG_CENTRE_ROW:    centre_row_next    = pwdata[7:0];
                REG_POINTS_IN_USE: points_in_use_next = pwdata[8:0];
                REG_MARKER_ENABLE: marker_enable_next = pwdata[0];
                REG_MARKER_COLUMN: marker_column_next = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_column_reg   <= RST_LEFT_COLUMN;
            right_column_reg  <= RST_RIGHT_COLUMN;
            top_row_reg       <= RST_TOP_ROW;
            bottom_row_reg    <= RST_BOTTOM_ROW;
            centre_row_reg    <= RST_CENTRE_ROW;
            points_in_use_reg <= RST_POINTS_IN_USE;
            marker_enable_reg <= RST_MARKER_ENABLE;
            marker_column_reg <= RST_MARKER_COLUMN;
        end else begin
            left_column_reg   <= left_column_next;
            right_column_reg  <= right_column_next;
            top_row_reg       <= top_row_next;
            bottom_row_reg    <= bottom_row_next;
            centre_row_reg    <= centre_row_next;
            points_in_use_reg <= points_in_use_next;
            marker_enable_reg <= marker_enable_next;
            marker_column_reg <= marker_column_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (cfg_index)
            REG_LEFT_COLUMN:   prdata = {24'd0, left_column_reg};
            REG_RIGHT_COLUMN:  prdata = {24'd0, right_column_reg};
            REG_TOP_ROW:       prdata = {24'd0, top_row_reg};
            REG_BOTTOM_ROW:    prdata = {24'd0, bottom_row_reg};
            REG_CENTRE_ROW:    prdata = {24'd0, centre_row_reg};
            REG_POINTS_IN_USE: prdata = {23'd0, points_in_use_reg};
            REG_MARKER_ENABLE: prdata = {31'd0, marker_enable_reg};
            REG_MARKER_COLUMN: prdata = {24'd0, marker_column_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic      p1_valid_reg, p1_valid_next;
    pix_info_t p1_info_reg;
    logic      m_valid_reg, m_valid_next;
    colour_t   m_colour_class_reg;
    logic [7:0] m_screen_column_reg;

    logic out_free;   // output register empty or being drained
    logic s_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Accept stage: window test and base class (grid/border, centre, background), memory access
    // ------------------------------------------------------------------
    logic             is_request;
    logic             store_ok;
    logic             win_ok;
    logic [8:0]       width9;
    logic [USE_W-1:0] cols_used;
    logic             hit;
    logic [7:0]       dy;
    logic [7:0]       screen_x;
    logic [7:0]       col_m1;
    logic             minor_hit, major_hit, border_hit;
    pix_info_t        info_next;

    assign is_request = (s_action == ACT_REQUEST);
    assign store_ok   = (s_action == ACT_STORE)
                      && (USE_W'(s_column_index) < USE_W'(SAMPLE_DEPTH));

    assign win_ok = (right_column_reg >= left_column_reg) && (top_row_reg <= bottom_row_reg);
    assign width9 = {1'b0, right_column_reg} - {1'b0, left_column_reg} + 9'd1;

    always_comb begin
        cols_used = USE_W'(width9);
        if (USE_W'(points_in_use_reg) < cols_used) begin
            cols_used = USE_W'(points_in_use_reg);
        end
        if (USE_W'(SAMPLE_DEPTH) < cols_used) begin
            cols_used = USE_W'(SAMPLE_DEPTH);
        end
    end

    assign hit = is_request && win_ok
               && (USE_W'(s_column_index) < cols_used)
               && (s_pixel_row >= top_row_reg) && (s_pixel_row <= bottom_row_reg);

    // x cannot wrap when hit: column offset stays inside the window
    assign screen_x = left_column_reg + s_column_index;
    assign dy       = s_pixel_row - top_row_reg;
    assign col_m1   = s_column_index - 8'd1;

    assign minor_hit  = is_multiple(s_column_index, 8'(MINOR_DX))
                      && is_multiple(dy, 8'(MINOR_DY));
    assign major_hit  = is_multiple(s_column_index, 8'(MAJOR_DX))
                      || is_multiple(dy, 8'(MAJOR_DY));
    assign border_hit = (s_column_index == 8'd0) || (screen_x == right_column_reg)
                      || (s_pixel_row == top_row_reg) || (s_pixel_row == bottom_row_reg);

    always_comb begin
        info_next.row        = s_pixel_row;
        info_next.screen_col = screen_x;
        info_next.col_zero   = (s_column_index == 8'd0);
        info_next.marker_hit = marker_enable_reg && (screen_x == marker_column_reg);
        priority if (border_hit) begin
            info_next.base_class = CLS_GRID;
        end else if (s_pixel_row == centre_row_reg) begin
            info_next.base_class = CLS_CENTRE;
        end else if (major_hit || minor_hit) begin
            info_next.base_class = CLS_GRID;
        end else begin
            info_next.base_class = CLS_BACKGROUND;
        end
    end

    logic [SAMPLE_W-1:0] cur_raw, prev_raw;

    wpc_sample_ram #(
        .DEPTH (SAMPLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (s_fire && store_ok),
        .wr_addr   (AW'(s_column_index)),
        .wr_data   (s_sample_row),
        .rd_en     (s_fire && is_request),
        .rd_addr_a (AW'(s_column_index)),
        .rd_addr_b (AW'(col_m1)),
        .rd_data_a (cur_raw),
        .rd_data_b (prev_raw)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_fire) begin
            p1_valid_next = hit;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_info_reg <= info_next;
        end
    end

    // ------------------------------------------------------------------
    // Class stage: clamp samples, trace span test, final class
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp_row(input logic signed [SAMPLE_W-1:0] s,
                                             input logic [7:0] lo_row,
                                             input logic [7:0] hi_row);
        logic signed [SAMPLE_W-1:0] lo_s;
        logic signed [SAMPLE_W-1:0] hi_s;
        lo_s = $signed({{(SAMPLE_W-8){1'b0}}, lo_row});
        hi_s = $signed({{(SAMPLE_W-8){1'b0}}, hi_row});
        if (s < lo_s) begin
            return lo_row;
        end else if (s > hi_s) begin
            return hi_row;
        end
        return s[7:0];
    endfunction

    logic [7:0] cur_row, prev_row, span_lo, span_hi;
    logic       trace_hit;
    colour_t    final_class;

    assign cur_row  = clamp_row($signed(cur_raw), top_row_reg, bottom_row_reg);
    assign prev_row = clamp_row($signed(prev_raw), top_row_reg, bottom_row_reg);
    assign span_lo  = (prev_row < cur_row) ? prev_row : cur_row;
    assign span_hi  = (prev_row > cur_row) ? prev_row : cur_row;

    assign trace_hit = (p1_info_reg.row == cur_row)
                     || (!p1_info_reg.col_zero
                         && (p1_info_reg.row >= span_lo) && (p1_info_reg.row <= span_hi));

    always_comb begin
        priority if (p1_info_reg.marker_hit) begin
            final_class = CLS_MARKER;
        end else if (trace_hit) begin
            final_class = CLS_TRACE;
        end else begin
            final_class = p1_info_reg.base_class;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p1_valid_reg) begin
            m_colour_class_reg  <= final_class;
            m_screen_column_reg <= p1_info_reg.screen_col;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_colour_class  = m_colour_class_reg;
    assign m_screen_column = m_screen_column_reg;

endmodule
`default_nettype wire
